// ===== src/sigact_pkg.sv =====
// Shared types and constants for the signal action association table.
// Holds the request/result transaction structs, function and status codes.
// No dependencies.
`default_nettype none

package sigact_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int SIGNALS_DEF = 32;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        func;
        logic [7:0]  signal_number;
        logic [31:0] handler_id;
        logic [31:0] action_mask;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] prev_handler;
        logic [31:0] prev_mask;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/signal_action_association_table_top.sv =====
// Top level of the signal action association table.
// Instantiates sigact_ctrl and sigact_mem; depends on sigact_pkg.
//
// Usage:
//   Request channel: drive request and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy stays high
//   while the request is being worked on.
//   Result channel: done is high for exactly one cycle with result valid in
//   that cycle. The receiver cannot stall; a result must be taken when shown.
//   Sequence: an invalid signal number is answered in the cycle after the
//   request is taken. Otherwise the block scans the valid entries one per
//   cycle through the memory read port, then decides and writes back up to
//   two entries before done rises.
//   A new request may be started in the cycle done is high.
//   Reset: the table comes up empty; the entry memory needs no clearing.
`default_nettype none

module signal_action_association_table_top #(
    parameter int ENTRIES = sigact_pkg::ENTRIES_DEF,
    parameter int SIGNALS = sigact_pkg::SIGNALS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sigact_pkg::req_t  request,
    output logic                   done,
    output sigact_pkg::rsp_t       result
);

    import sigact_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DW = SIGNALS + 64;

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [DW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;

    sigact_ctrl #(
        .ENTRIES (ENTRIES),
        .SIGNALS (SIGNALS),
        .AW      (AW),
        .DW      (DW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    sigact_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (DW),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule

`default_nettype wire

// ===== src/sigact_mem.sv =====
// Entry store: one synchronous single-port-per-direction memory.
// One write and one registered read per cycle. No dependencies.
`default_nettype none

module sigact_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 96,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sigact_ctrl.sv =====
// Sequencer for the association table: scans the entry memory, decides the
// update and writes it back. Depends on sigact_pkg.
`default_nettype none

module sigact_ctrl #(
    parameter int ENTRIES = sigact_pkg::ENTRIES_DEF,
    parameter int SIGNALS = sigact_pkg::SIGNALS_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int DW      = SIGNALS + 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sigact_pkg::req_t  request,
    output logic                   done,
    output sigact_pkg::rsp_t       result,
    output logic                   mem_rd_en,
    output logic [AW-1:0]          mem_rd_addr,
    input  wire logic [DW-1:0]     mem_rd_data,
    output logic                   mem_wr_en,
    output logic [AW-1:0]          mem_wr_addr,
    output logic [DW-1:0]          mem_wr_data
);

    import sigact_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = $clog2(SIGNALS);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_WR1, S_WR2} state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     issue_reg;
    logic              pend_reg;
    logic [CW-1:0]     pend_idx_reg;
    logic              found_n_reg;
    logic              found_a_reg;
    logic              done_reg;
    rsp_t              result_reg;

    // request and scan payload
    logic [SW-1:0]      sig_reg;
    logic               func_reg;
    logic [31:0]        h_reg;
    logic [31:0]        m_reg;
    logic [AW-1:0]      n_idx_reg;
    logic [SIGNALS-1:0] n_sig_reg;
    logic [31:0]        n_h_reg;
    logic [31:0]        n_m_reg;
    logic [AW-1:0]      a_idx_reg;
    logic [SIGNALS-1:0] a_sig_reg;
    logic [SIGNALS-1:0] last_sig_reg;
    logic [31:0]        last_h_reg;
    logic [31:0]        last_m_reg;
    logic               wr1_en_reg;
    logic [AW-1:0]      wr1_addr_reg;
    logic [DW-1:0]      wr1_data_reg;
    logic               wr2_en_reg;
    logic [AW-1:0]      wr2_addr_reg;
    logic [DW-1:0]      wr2_data_reg;

    logic               sig_valid;
    logic [SIGNALS-1:0] rd_sig;
    logic [31:0]        rd_h;
    logic [31:0]        rd_m;
    logic               hit_n;
    logic               hit_a;
    logic               scan_last;

    logic [SIGNALS-1:0] bit_v;
    logic [SIGNALS-1:0] n_clr;
    logic               n_empty;
    logic [CW-1:0]      last_idx;
    logic               a_is_last;
    logic [SIGNALS-1:0] last_sig_eff;
    logic [DW-1:0]      n_new;
    logic [CW-1:0]      cnt_after_clr;
    rsp_t               dec_result;
    logic               dec_wr1_en;
    logic [AW-1:0]      dec_wr1_addr;
    logic [DW-1:0]      dec_wr1_data;
    logic               dec_wr2_en;
    logic [AW-1:0]      dec_wr2_addr;
    logic [DW-1:0]      dec_wr2_data;

    assign sig_valid = ({1'b0, request.signal_number} < 9'(SIGNALS));

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign mem_rd_en   = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign mem_rd_addr = issue_reg[AW-1:0];
    assign mem_wr_en   = (state_reg == S_WR1) || (state_reg == S_WR2);
    assign mem_wr_addr = (state_reg == S_WR1) ? wr1_addr_reg : wr2_addr_reg;
    assign mem_wr_data = (state_reg == S_WR1) ? wr1_data_reg : wr2_data_reg;

    assign rd_sig    = mem_rd_data[DW-1:64];
    assign rd_h      = mem_rd_data[63:32];
    assign rd_m      = mem_rd_data[31:0];
    assign hit_n     = rd_sig[sig_reg];
    assign hit_a     = (rd_h == h_reg) && (rd_m == m_reg);
    assign scan_last = (pend_idx_reg == (count_reg - CW'(1)));

    // Update plan from the scan results
    always_comb
    begin
        bit_v         = {{(SIGNALS-1){1'b0}}, 1'b1} << sig_reg;
        n_clr         = n_sig_reg & ~bit_v;
        n_empty       = (n_clr == '0);
        last_idx      = count_reg - CW'(1);
        a_is_last     = (a_idx_reg == last_idx[AW-1:0]);
        // the last entry may already carry the bit added to the matching entry
        last_sig_eff  = last_sig_reg | ((found_a_reg && a_is_last) ? bit_v : '0);
        n_new         = n_empty ? {last_sig_eff, last_h_reg, last_m_reg}
                                : {n_clr, n_h_reg, n_m_reg};
        cnt_after_clr = (found_n_reg && n_empty) ? (count_reg - CW'(1)) : count_reg;

        dec_result   = '{status: ST_OK, prev_handler: 32'd0, prev_mask: 32'd0};
        dec_wr1_en   = 1'b0;
        dec_wr1_addr = n_idx_reg;
        dec_wr1_data = n_new;
        dec_wr2_en   = 1'b0;
        dec_wr2_addr = n_idx_reg;
        dec_wr2_data = n_new;
        count_next   = count_reg;

        if (func_reg == FUNC_GET)
        begin
            if (found_n_reg)
            begin
                dec_result.prev_handler = n_h_reg;
                dec_result.prev_mask    = n_m_reg;
            end
        end
        else if (h_reg == 32'd0)
        begin
            if (found_n_reg)
            begin
                dec_result.prev_handler = n_h_reg;
                dec_result.prev_mask    = n_m_reg;
                dec_wr1_en              = 1'b1;
                count_next              = cnt_after_clr;
            end
        end
        else if (found_a_reg)
        begin
            if (found_n_reg && (n_idx_reg == a_idx_reg))
            begin
                dec_result.prev_handler = h_reg;
                dec_result.prev_mask    = m_reg;
            end
            else
            begin
                dec_wr1_en   = 1'b1;
                dec_wr1_addr = a_idx_reg;
                dec_wr1_data = {a_sig_reg | bit_v, h_reg, m_reg};
                if (found_n_reg)
                begin
                    dec_result.prev_handler = n_h_reg;
                    dec_result.prev_mask    = n_m_reg;
                    dec_wr2_en              = 1'b1;
                    count_next              = cnt_after_clr;
                end
            end
        end
        else if ((count_reg >= CW'(ENTRIES)) && (!found_n_reg || (n_sig_reg != bit_v)))
        begin
            dec_result.status = ST_FULL;
        end
        else
        begin
            if (found_n_reg)
            begin
                dec_result.prev_handler = n_h_reg;
                dec_result.prev_mask    = n_m_reg;
                dec_wr1_en              = 1'b1;
            end
            // append after any removal
            dec_wr2_en   = 1'b1;
            dec_wr2_addr = cnt_after_clr[AW-1:0];
            dec_wr2_data = {bit_v, h_reg, m_reg};
            count_next   = cnt_after_clr + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            found_n_reg  <= 1'b0;
            found_a_reg  <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (!sig_valid)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_INVALID, prev_handler: 32'd0,
                                            prev_mask: 32'd0};
                        end
                        else
                        begin
                            state_reg   <= S_SCAN;
                            issue_reg   <= '0;
                            pend_reg    <= 1'b0;
                            found_n_reg <= 1'b0;
                            found_a_reg <= 1'b0;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= mem_rd_en;
                    pend_idx_reg <= issue_reg;
                    if (mem_rd_en)
                    begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    if (pend_reg)
                    begin
                        if (hit_n)
                        begin
                            found_n_reg <= 1'b1;
                        end
                        if (hit_a)
                        begin
                            found_a_reg <= 1'b1;
                        end
                    end
                    if (!mem_rd_en && !pend_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    result_reg <= dec_result;
                    count_reg  <= count_next;
                    if (dec_wr1_en)
                    begin
                        state_reg <= S_WR1;
                    end
                    else if (dec_wr2_en)
                    begin
                        state_reg <= S_WR2;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_WR1:
                begin
                    if (wr2_en_reg)
                    begin
                        state_reg <= S_WR2;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_WR2:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload capture: request, first hits of the scan, the last entry, write plan
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            func_reg <= request.func;
            sig_reg  <= request.signal_number[SW-1:0];
            h_reg    <= request.handler_id;
            m_reg    <= request.action_mask;
        end
        if ((state_reg == S_SCAN) && pend_reg)
        begin
            if (hit_n && !found_n_reg)
            begin
                n_idx_reg <= pend_idx_reg[AW-1:0];
                n_sig_reg <= rd_sig;
                n_h_reg   <= rd_h;
                n_m_reg   <= rd_m;
            end
            if (hit_a && !found_a_reg)
            begin
                a_idx_reg <= pend_idx_reg[AW-1:0];
                a_sig_reg <= rd_sig;
            end
            if (scan_last)
            begin
                last_sig_reg <= rd_sig;
                last_h_reg   <= rd_h;
                last_m_reg   <= rd_m;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            wr1_en_reg   <= dec_wr1_en;
            wr1_addr_reg <= dec_wr1_addr;
            wr1_data_reg <= dec_wr1_data;
            wr2_en_reg   <= dec_wr2_en;
            wr2_addr_reg <= dec_wr2_addr;
            wr2_data_reg <= dec_wr2_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/sigact_chk.sv =====
// Port-level checker for the association table, bound to the top level.
// Depends on sigact_pkg.
`default_nettype none

module sigact_chk (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              done,
    input  wire sigact_pkg::rsp_t  result
);

    import sigact_pkg::*;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("taken transaction neither worked on nor answered");

    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_INVALID ||
                  result.status == ST_FULL))
        else $error("undefined status code");

    a_fail_default: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_INVALID || result.status == ST_FULL)) |->
        (result.prev_handler == 32'd0 && result.prev_mask == 32'd0))
        else $error("failed transaction returned an action");

endmodule

bind signal_action_association_table_top sigact_chk u_sigact_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// ===== sim/signal_action_association_table_top_tb.sv =====
// Self-checking testbench for signal_action_association_table_top.
// Runs get/set/clear transactions, directed and random, against its own model of the table.
// Depends on sigact_pkg and the RTL under src.
`default_nettype none

module signal_action_association_table_top_tb;

    import sigact_pkg::*;

    localparam int NUM_ENTRIES = ENTRIES_DEF;
    localparam int NUM_SIGNALS = SIGNALS_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    // own copy of the table
    logic [NUM_SIGNALS-1:0] grp_sigs[NUM_ENTRIES];
    logic [31:0]            grp_handler[NUM_ENTRIES];
    logic [31:0]            grp_mask[NUM_ENTRIES];
    int                     grp_count;

    rsp_t      awaited_actions[$];
    stim_row_t dir_rows[$];
    int        mismatches;

    signal_action_association_table_top #(
        .ENTRIES(NUM_ENTRIES),
        .SIGNALS(NUM_SIGNALS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

    // Take a signal out of its group; an emptied group is replaced by the last one.
    function automatic void release_signal(int idx, int sig);
        int last;
        grp_sigs[idx][sig] = 1'b0;
        if (grp_sigs[idx] == '0 && grp_count > 0)
        begin
            last = grp_count - 1;
            grp_sigs[idx] = grp_sigs[last];
            grp_handler[idx] = grp_handler[last];
            grp_mask[idx] = grp_mask[last];
            grp_sigs[last] = '0;
            grp_handler[last] = '0;
            grp_mask[last] = '0;
            grp_count = last;
        end
    endfunction

    function automatic rsp_t predict_action(req_t r);
        rsp_t                   o;
        int                     sig;
        int                     by_sig;
        int                     by_act;
        logic [NUM_SIGNALS-1:0] sig_bit;
        o = '0;
        o.status = ST_OK;
        if (r.signal_number >= NUM_SIGNALS)
        begin
            o.status = ST_INVALID;
            return o;
        end
        sig = r.signal_number;
        sig_bit = '0;
        sig_bit[sig] = 1'b1;
        by_sig = grp_count;
        by_act = grp_count;
        for (int i = 0; i < grp_count; i++)
        begin
            if (by_sig == grp_count && grp_sigs[i][sig])
                by_sig = i;
            if (by_act == grp_count && grp_handler[i] == r.handler_id
                    && grp_mask[i] == r.action_mask)
                by_act = i;
        end
        if (r.func == FUNC_GET)
        begin
            if (by_sig < grp_count)
            begin
                o.prev_handler = grp_handler[by_sig];
                o.prev_mask = grp_mask[by_sig];
            end
        end
        else if (r.handler_id == '0)
        begin
            if (by_sig < grp_count)
            begin
                o.prev_handler = grp_handler[by_sig];
                o.prev_mask = grp_mask[by_sig];
                release_signal(by_sig, sig);
            end
        end
        else if (by_act < grp_count)
        begin
            if (by_sig == by_act)
            begin
                o.prev_handler = r.handler_id;
                o.prev_mask = r.action_mask;
            end
            else
            begin
                grp_sigs[by_act] = grp_sigs[by_act] | sig_bit;
                if (by_sig < grp_count)
                begin
                    o.prev_handler = grp_handler[by_sig];
                    o.prev_mask = grp_mask[by_sig];
                    release_signal(by_sig, sig);
                end
            end
        end
        // a full table still takes a set whose signal sits alone in its group
        else if (grp_count >= NUM_ENTRIES
                && (by_sig >= grp_count || grp_sigs[by_sig] != sig_bit))
        begin
            o.status = ST_FULL;
        end
        else
        begin
            if (by_sig < grp_count)
            begin
                o.prev_handler = grp_handler[by_sig];
                o.prev_mask = grp_mask[by_sig];
                release_signal(by_sig, sig);
            end
            if (grp_count < NUM_ENTRIES)
            begin
                grp_sigs[grp_count] = sig_bit;
                grp_handler[grp_count] = r.handler_id;
                grp_mask[grp_count] = r.action_mask;
                grp_count++;
            end
        end
        return o;
    endfunction

    function automatic void add_row(logic fn, logic [7:0] sig, logic [31:0] h, logic [31:0] m,
                                    bit known, logic [1:0] st, logic [31:0] ph, logic [31:0] pm);
        stim_row_t row;
        row.req.func = fn;
        row.req.signal_number = sig;
        row.req.handler_id = h;
        row.req.action_mask = m;
        row.known = known;
        row.want.status = st;
        row.want.prev_handler = ph;
        row.want.prev_mask = pm;
        dir_rows.push_back(row);
    endfunction

    function automatic req_t pick_request();
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        r.func = (roll < 30) ? FUNC_GET : FUNC_SET;
        if ($urandom_range(0, 9) == 0)
            r.signal_number = 8'($urandom_range(32, 255));
        else
            r.signal_number = 8'($urandom_range(0, NUM_SIGNALS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            r.handler_id = '0;
            r.action_mask = $urandom();
        end
        else if (roll < 30)
        begin
            r.handler_id = $urandom();
            r.action_mask = $urandom();
        end
        else
        begin
            // small pool of actions so that signals share groups and the table fills
            r.handler_id = 32'($urandom_range(1, 6));
            r.action_mask = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send(req_t r, int gap, bit known, rsp_t want);
        rsp_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_action(r);
        awaited_actions.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_actions.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = awaited_actions.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("prev_handler", want.prev_handler, result.prev_handler);
                check_field("prev_mask", want.prev_mask, result.prev_mask);
            end
        end
    end

    initial
    begin : stimulus
        rsp_t none;
        int   gap;
        bit   calm;
        none = '0;
        mismatches = 0;
        grp_count = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            grp_sigs[i] = '0;
            grp_handler[i] = '0;
            grp_mask[i] = '0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;

        add_row(FUNC_GET, 8'd0, 32'h0, 32'h0, 1, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_GET, 8'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_GET, 8'd32, 32'h0, 32'h0, 1, ST_INVALID, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_INVALID, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd5, 32'h0, 32'h0, 1, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(FUNC_SET, 8'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_GET, 8'd31, 32'h0, 32'h0, 1, ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(FUNC_SET, 8'd0, 32'h1, 32'h0, 0, ST_OK, 32'h0, 32'h0);
        // fill the remaining six groups, one signal each
        for (int s = 1; s <= 6; s++)
            add_row(FUNC_SET, 8'(s), 32'(s + 1), 32'hA5A5_0000 | 32'(s), 0,
                    ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd7, 32'h8, 32'h0, 1, ST_FULL, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd1, 32'h9, 32'h9, 0, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd31, 32'h0, 32'h0, 0, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd7, 32'h8, 32'h0, 0, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd2, 32'h1, 32'h0, 0, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_GET, 8'd2, 32'h0, 32'h0, 0, ST_OK, 32'h0, 32'h0);
        add_row(FUNC_SET, 8'd0, 32'h0, 32'h0, 0, ST_OK, 32'h0, 32'h0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].req, $urandom_range(0, 3), dir_rows[i].known, dir_rows[i].want);

        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate stretches of back-to-back transactions with gappy ones
            if (n % 50 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 10);
            send(pick_request(), gap, 0, none);
        end
        start <= 1'b0;

        for (int c = 0; c < 1000 && awaited_actions.size() != 0; c++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        while (awaited_actions.size() != 0)
        begin
            $display("%0t: result never arrived, expected %p", $time,
                     awaited_actions.pop_front());
            mismatches++;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== signal_action_association_table_top.f =====
src/sigact_pkg.sv
src/sigact_mem.sv
src/sigact_ctrl.sv
src/signal_action_association_table_top.sv
src/sigact_chk.sv
sim/signal_action_association_table_top_tb.sv
